>>> rtl/restoring_binary_divider_macros.svh
// ----------------------------------------------------------------------------
// Restoring binary divider assertion macros
// Clocked property wrappers with reset disable, shared by the checker.
// ----------------------------------------------------------------------------
`ifndef RESTORING_BINARY_DIVIDER_MACROS_SVH
`define RESTORING_BINARY_DIVIDER_MACROS_SVH

// same-cycle implication
`define RBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbd assertion failed");

// next-cycle implication
`define RBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbd assertion failed");

`endif

>>> rtl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// Restoring binary divider package
// Shared widths, defaults and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int unsigned DataW        = 64;
  localparam int unsigned WidthDefault = 64;

  typedef struct packed {
    logic load;  // take new operands
    logic step;  // one restoring step
    logic emit;  // move result into output register
  } rbd_cmd_t;

  typedef struct packed {
    logic last_step;
  } rbd_status_t;

endpackage

>>> rtl/restoring_binary_divider.sv
// ----------------------------------------------------------------------------
// Restoring binary divider
// Each item is stepped one quotient bit per cycle through the single shared
// WIDTH+1-bit subtractor; its result is registered once the output is free,
// and no new item is taken before that hand-off.
// Reset: controller idle, no result pending; no clearing pass.
// ----------------------------------------------------------------------------
module restoring_binary_divider import rbd_pkg::*; #(
  parameter int unsigned WIDTH = WidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] quotient_o,
  output logic [DataW-1:0] remainder_o,
  output logic             divide_by_zero_o
);

  rbd_cmd_t    cmd;
  rbd_status_t status;

  rbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rbd_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .dividend_i       (dividend_i),
    .divisor_i        (divisor_i),
    .quotient_o       (quotient_o),
    .remainder_o      (remainder_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

endmodule

>>> rtl/rbd_datapath.sv
// ----------------------------------------------------------------------------
// Restoring divider datapath
// Partial remainder, shifting dividend/quotient, step counter, output regs.
// ----------------------------------------------------------------------------
module rbd_datapath import rbd_pkg::*; #(
  parameter int unsigned WIDTH = WidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rbd_cmd_t         cmd_i,
  output rbd_status_t      status_o,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic [DataW-1:0] quotient_o,
  output logic [DataW-1:0] remainder_o,
  output logic             divide_by_zero_o
);

  localparam int unsigned CntW = $clog2(WIDTH);

  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] nq_q, nq_d;     // dividend bits out at the top, quotient bits in
  logic [WIDTH-1:0] dvs_q;
  logic             dbz_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [DataW-1:0] quo_out_q, rem_out_q;
  logic             dbz_out_q;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             qbit;

  assign trial = {rem_q, nq_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = ~diff[WIDTH];

  always_comb begin
    rem_d = rem_q;
    nq_d  = nq_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      rem_d = '0;
      nq_d  = dividend_i[WIDTH-1:0];
      cnt_d = CntW'(WIDTH - 1);
    end else if (cmd_i.step) begin
      rem_d = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      nq_d  = {nq_q[WIDTH-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    if (cmd_i.load) begin
      dvs_q <= divisor_i[WIDTH-1:0];
      dbz_q <= (divisor_i[WIDTH-1:0] == '0);
    end
    if (cmd_i.emit) begin
      quo_out_q <= dbz_q ? '0 : DataW'(nq_q);
      rem_out_q <= dbz_q ? '0 : DataW'(rem_q);
      dbz_out_q <= dbz_q;
    end
  end

  assign status_o.last_step = (cnt_q == '0);
  assign quotient_o         = quo_out_q;
  assign remainder_o        = rem_out_q;
  assign divide_by_zero_o   = dbz_out_q;

endmodule

>>> rtl/rbd_ctrl.sv
// ----------------------------------------------------------------------------
// Restoring divider controller
// Sequences load, WIDTH steps and result hand-off; owns output valid.
// ----------------------------------------------------------------------------
module rbd_ctrl import rbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  rbd_status_t status_i,
  output rbd_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StDone = 3'b100
  } rbd_state_e;

  rbd_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       in_ready;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    in_ready = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        cmd_o.step = 1'b1;
        if (status_i.last_step) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          in_ready   = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = StRun;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/restoring_binary_divider_checker.sv
// ----------------------------------------------------------------------------
// Restoring binary divider checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "restoring_binary_divider_macros.svh"

module restoring_binary_divider_checker import rbd_pkg::*; #(
  parameter int unsigned WIDTH = WidthDefault
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [DataW-1:0] quotient_o,
  input logic [DataW-1:0] remainder_o,
  input logic             divide_by_zero_o
);

  logic in_fire;
  logic out_stall;
  logic hi_clear;

  assign in_fire   = in_valid_i & in_ready_o;
  assign out_stall = out_valid_o & ~out_ready_i;
  assign hi_clear  = ((quotient_o >> WIDTH) == '0) && ((remainder_o >> WIDTH) == '0);

  // a stalled result holds
  `RBD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall,
                   out_valid_o && $stable(quotient_o) && $stable(remainder_o))

  // an accepted item keeps the divider busy the next cycle
  `RBD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_ready_o)

  // zero divisor gives zero quotient and remainder
  `RBD_ASSERT_NOW(a_dbz_zero, clk_i, rst_ni, out_valid_o && divide_by_zero_o,
                  quotient_o == '0 && remainder_o == '0)

  // nothing above WIDTH bits
  `RBD_ASSERT_NOW(a_width_bound, clk_i, rst_ni, out_valid_o, hi_clear)

endmodule

bind restoring_binary_divider restoring_binary_divider_checker #(
  .WIDTH (WIDTH)
) u_checker (.*);
